[rtl/core/pftd_pkg.sv]
// ---------------------------------------------------------------------------
// pftd_pkg - shared types and constants for the trial-division factorizer
// Data width, command/status bundles between controller and datapath, and
// the selector for what goes into the result register.
// ---------------------------------------------------------------------------
package pftd_pkg;

  // Width of the number and of every factor
  localparam int DATA_W = 32;
  // Bits of the serial divider step counter
  localparam int CNT_W  = $clog2(DATA_W);

  // Source of the factor field on an emitted item
  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,   // zero or one: no factor
    SEL_DIVISOR = 2'd1,   // current trial divisor divides the residue
    SEL_RESIDUE = 2'd2    // leftover residue is prime
  } emit_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic      load;       // latch new number, divisor back to 2
    logic      div_start;  // start residue / divisor
    logic      upd_res;    // residue <= quotient
    logic      inc_div;    // divisor <= divisor + 1
    logic      emit;       // load result register
    emit_sel_t sel;
    logic      last;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic res_lt2;    // residue below 2
    logic div_busy;
    logic div_done;   // quotient and remainder valid
    logic d_gt_q;     // divisor above quotient: divisor squared exceeds residue
    logic rem_zero;
    logic q_one;
    logic out_free;   // result register can take an item this cycle
  } stat_t;

endpackage

[rtl/core/pftd_div.sv]
// ---------------------------------------------------------------------------
// pftd_div - serial restoring divider
// One quotient bit per cycle. Results hold
// until the next start.
// ---------------------------------------------------------------------------
module pftd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pftd_pkg::DATA_W-1:0] dividend,
  input  logic [pftd_pkg::DATA_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [pftd_pkg::DATA_W-1:0] quotient,
  output logic [pftd_pkg::DATA_W-1:0] remainder
);
  import pftd_pkg::*;

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   trial;
  logic              ge;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial   = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};
    ge      = ~trial[DATA_W];
    rem_nxt = ge ? trial[DATA_W-1:0] : {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
    quo_nxt = {quo_r[DATA_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/core/pftd_dp.sv]
// ---------------------------------------------------------------------------
// pftd_dp - factorizer datapath
// Residue and trial divisor registers, the serial divider and the result
// register that parts the result channel from the working loop.
// ---------------------------------------------------------------------------
module pftd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pftd_pkg::cmd_t              cmd,
  output pftd_pkg::stat_t             stat,
  input  logic [pftd_pkg::DATA_W-1:0] in_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pftd_pkg::DATA_W-1:0] out_factor,
  output logic                        out_has_factor,
  output logic                        out_last
);
  import pftd_pkg::*;

  logic [DATA_W-1:0] residue_r;
  logic [DATA_W-1:0] divisor_r;
  logic [DATA_W-1:0] quo, rem;
  logic              div_busy, div_done;
  logic              out_valid_r;
  logic [DATA_W-1:0] factor_r;
  logic              has_r, last_r;
  logic [DATA_W-1:0] factor_nxt;
  logic              has_nxt;

  pftd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (residue_r),
    .divisor   (divisor_r),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // residue and trial divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r <= '0;
      divisor_r <= '0;
    end else if (cmd.load) begin
      residue_r <= in_number;
      divisor_r <= DATA_W'(2);
    end else begin
      if (cmd.upd_res) residue_r <= quo;
      if (cmd.inc_div) divisor_r <= divisor_r + 1'b1;
    end
  end

  // factor selection for the next item
  always_comb begin
    case (cmd.sel)
      SEL_DIVISOR: begin
        factor_nxt = divisor_r;
        has_nxt    = 1'b1;
      end
      SEL_RESIDUE: begin
        factor_nxt = residue_r;
        has_nxt    = 1'b1;
      end
      default: begin
        factor_nxt = '0;
        has_nxt    = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      factor_r <= factor_nxt;
      has_r    <= has_nxt;
      last_r   <= cmd.last;
    end
  end

  // status back to the controller
  always_comb begin
    stat.res_lt2  = (residue_r[DATA_W-1:1] == '0);
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.d_gt_q   = (divisor_r > quo);
    stat.rem_zero = (rem == '0);
    stat.q_one    = (quo == DATA_W'(1));
    stat.out_free = ~out_valid_r | ~out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_factor     = factor_r;
  assign out_has_factor = has_r;
  assign out_last       = last_r;

endmodule

[rtl/core/pftd_ctrl.sv]
// ---------------------------------------------------------------------------
// pftd_ctrl - factorizer sequencer
// Walks the trial divisors: an outer test per divisor (also checks the
// square bound) and an inner repeat while the divisor keeps dividing.
// ---------------------------------------------------------------------------
module pftd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pftd_pkg::stat_t stat,
  output pftd_pkg::cmd_t  cmd
);
  import pftd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_START_O = 6'b000100,
    S_WAIT_O  = 6'b001000,
    S_START_I = 6'b010000,
    S_WAIT_I  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // zero or one: a single empty item
        if (!stat.res_lt2) begin
          state_nxt = S_START_O;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_NONE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_START_O: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT_O;
      end
      S_WAIT_O: begin
        if (stat.div_done) begin
          if (stat.d_gt_q) begin
            // divisor squared above residue: residue is the last prime
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = SEL_RESIDUE;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (stat.rem_zero) begin
            // quotient is at least the divisor here, so never last
            if (stat.out_free) begin
              cmd.emit    = 1'b1;
              cmd.sel     = SEL_DIVISOR;
              cmd.upd_res = 1'b1;
              state_nxt   = S_START_I;
            end
          end else begin
            cmd.inc_div = 1'b1;
            state_nxt   = S_START_O;
          end
        end
      end
      S_START_I: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            if (stat.out_free) begin
              cmd.emit    = 1'b1;
              cmd.sel     = SEL_DIVISOR;
              cmd.last    = stat.q_one;
              cmd.upd_res = 1'b1;
              state_nxt   = stat.q_one ? S_IDLE : S_START_I;
            end
          end else begin
            cmd.inc_div = 1'b1;
            state_nxt   = S_START_O;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/prime_factorizer_trial_division_core.sv]
// ---------------------------------------------------------------------------
// prime_factorizer_trial_division_core - prime factorization by trial division
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_number[31:0]
//   out_     output     out_valid/out_stall out_factor[31:0], out_has_factor,
//                                           out_last
//
// Each trial divisor costs one serial division plus sequencing; a 32-bit
// prime needs up to 65535 trials. Reset is synchronous and clears all
// control state. A stalled result register holds the sequencer at the next
// factor; a new item is taken as soon as the last result sits in the result
// register.
// ---------------------------------------------------------------------------
module prime_factorizer_trial_division_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pftd_pkg::DATA_W-1:0] in_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pftd_pkg::DATA_W-1:0] out_factor,
  output logic                        out_has_factor,
  output logic                        out_last
);
  import pftd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pftd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pftd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_factor     (out_factor),
    .out_has_factor (out_has_factor),
    .out_last       (out_last)
  );

`ifndef ASSERT_OFF
  // never overwrite an item still waiting in the result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result register overwritten");

  // a new item is only taken with the divider quiet
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !stat.div_busy)
    else $error("item accepted during division");

  // a started division never reports stale results
  a_div_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (stat.div_busy && !stat.div_done))
    else $error("divider done flag not cleared on start");

  // a divisor factor is always at least two
  a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == SEL_DIVISOR) |=> (out_has_factor && out_factor > 1))
    else $error("emitted divisor factor below two");
`endif

endmodule
